### src/vrt_pkg.sv
// shared constants, types and helpers for the voxel ray traversal block
// no dependencies
`default_nettype none
package vrt_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int ADDR_W        = 15;
  localparam int STORE_DEPTH   = 32768;
  localparam int CELL_W        = 8;
  localparam int T_W           = 32;
  localparam int NUM_W         = 25;
  localparam int DEN_W         = 16;

  localparam logic [T_W-1:0]   T_NEVER  = '1;
  localparam logic [NUM_W-1:0] STEP_NUM = NUM_W'(1) << 24;

  localparam logic ACT_CAST = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // magnitude of a signed direction, the most negative value maps to 32768
  function automatic logic [DEN_W-1:0] dir_mag(input logic signed [15:0] d);
    logic [DEN_W-1:0] m;
    m = d[15] ? DEN_W'(-d) : DEN_W'(d);
    return m;
  endfunction

endpackage
`default_nettype wire

### src/vrt_mem.sv
// voxel count store: one write port, one read port with registered data
// depends on vrt_pkg
`default_nettype none
module vrt_mem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [vrt_pkg::ADDR_W-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic [vrt_pkg::ADDR_W-1:0] raddr,
  output logic      [7:0]                rdata
);

  logic [7:0] mem [vrt_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/vrt_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on vrt_pkg
`default_nettype none
module vrt_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire vrt_pkg::div_req_t        req,
  output logic                          done,
  output logic [vrt_pkg::NUM_W-1:0]     quo
);

  localparam int CNT_W = $clog2(vrt_pkg::NUM_W);

  logic [vrt_pkg::DEN_W-1:0] rem;
  logic [vrt_pkg::NUM_W-1:0] q;
  logic [CNT_W-1:0]          cnt;
  logic                      active;
  logic [vrt_pkg::DEN_W:0]   trial;
  logic                      qbit;
  logic [vrt_pkg::DEN_W:0]   diff;

  always_comb begin
    trial = {rem, q[vrt_pkg::NUM_W-1]};
    diff  = trial - {1'b0, req.den};
    qbit  = (trial >= {1'b0, req.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        q      <= req.num;
      end else if (active) begin
        rem <= qbit ? diff[vrt_pkg::DEN_W-1:0] : trial[vrt_pkg::DEN_W-1:0];
        q   <= {q[vrt_pkg::NUM_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(vrt_pkg::NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule
`default_nettype wire

### src/voxel_ray_traversal_accumulate.sv
// voxel ray traversal top: sequencer, crossing registers, divider and store
// depends on vrt_pkg, vrt_div, vrt_mem
// after reset every store address is zeroed with busy high
// read item: the store read is registered, then the result in S_RDWAIT; rejected cast: result in the cycle after start
// cast item: 6 divisions, then a store read then write per marked voxel
// (S_MREAD then S_MWRITE); one item at a time
// results are strobed on done for one cycle; the receiver cannot stall
`default_nettype none
module voxel_ray_traversal_accumulate #(
  parameter int GRID_SIZE = vrt_pkg::GRID_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [12:0] origin_x,
  input  wire logic [12:0] origin_y,
  input  wire logic [12:0] origin_z,
  input  wire logic [15:0] dir_x,
  input  wire logic [15:0] dir_y,
  input  wire logic [15:0] dir_z,
  input  wire logic [14:0] read_index,
  output logic             done,
  output logic [7:0]       voxel_value,
  output logic [6:0]       marked_count,
  output logic             rejected,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int CW = vrt_pkg::CELL_W;
  localparam logic signed [CW-1:0] G_C = CW'(GRID_SIZE);
  localparam logic [23:0] G1 = 24'(GRID_SIZE);
  localparam logic [23:0] G2 = 24'(GRID_SIZE * GRID_SIZE);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_RDWAIT  = 7'b0000100,
    S_DIVGO   = 7'b0001000,
    S_DIVWAIT = 7'b0010000,
    S_MREAD   = 7'b0100000,
    S_MWRITE  = 7'b1000000
  } state_t;

  state_t state;
  logic [vrt_pkg::ADDR_W-1:0] clr_cnt;
  logic [7:0] darken;

  logic signed [15:0]       dir_r  [3];
  logic [7:0]               frac_r [3];
  logic signed [CW-1:0]     cpos   [3];
  logic [vrt_pkg::T_W-1:0]  ncross [3];
  logic [vrt_pkg::T_W-1:0]  cstep  [3];
  logic [6:0]               mcnt;
  logic [2:0]               didx;

  // store port
  logic                       mem_we;
  logic [vrt_pkg::ADDR_W-1:0] mem_waddr;
  logic [7:0]                 mem_wdata;
  logic [vrt_pkg::ADDR_W-1:0] mem_raddr;
  logic [7:0]                 mem_rdata;
  logic [vrt_pkg::ADDR_W-1:0] cur_addr;
  logic [23:0]                lin;

  // divider
  vrt_pkg::div_req_t          dreq;
  logic                       ddone;
  logic [vrt_pkg::NUM_W-1:0]  dquo;
  logic [1:0]                 dax;
  logic                       dpos;
  logic [8:0]                 dlen;
  logic [vrt_pkg::DEN_W-1:0]  dmag;
  logic [vrt_pkg::T_W-1:0]    dval;

  // walk step
  logic [1:0]               ax;
  logic                     spos;
  logic signed [CW-1:0]     cell_new;
  logic                     hit;
  logic [vrt_pkg::T_W:0]    tsum;
  logic [6:0]               mcnt_next;
  logic                     accept;
  logic [4:0]               ip_x, ip_y, ip_z;
  logic                     out_of_grid;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  assign ip_x = origin_x[12:8];
  assign ip_y = origin_y[12:8];
  assign ip_z = origin_z[12:8];
  assign out_of_grid = ($signed({3'b000, ip_x}) >= G_C) || ($signed({3'b000, ip_y}) >= G_C) ||
                       ($signed({3'b000, ip_z}) >= G_C);

  always_comb begin
    lin = 24'(cpos[0][6:0]) + G1 * 24'(cpos[1][6:0]) + G2 * 24'(cpos[2][6:0]);
    cur_addr = lin[vrt_pkg::ADDR_W-1:0];
  end

  always_comb begin
    dax  = didx[2:1];
    dpos = (dir_r[dax] > 16'sd0);
    dlen = dpos ? (9'd256 - {1'b0, frac_r[dax]}) : {1'b0, frac_r[dax]};
    dmag = vrt_pkg::dir_mag(dir_r[dax]);
    dreq.go  = (state == S_DIVGO);
    dreq.num = didx[0] ? {dlen, 16'b0} : vrt_pkg::STEP_NUM;
    dreq.den = (dmag == '0) ? vrt_pkg::DEN_W'(1) : dmag;
    dval = (dir_r[dax] == 16'sd0) ? vrt_pkg::T_NEVER : vrt_pkg::T_W'(dquo);
  end

  // strict-less compares: on a tie the later axis wins, z over y over x
  always_comb begin
    if (ncross[0] < ncross[1]) begin
      ax = (ncross[0] < ncross[2]) ? 2'd0 : 2'd2;
    end else begin
      ax = (ncross[1] < ncross[2]) ? 2'd1 : 2'd2;
    end
    spos     = (dir_r[ax] > 16'sd0);
    cell_new = spos ? cpos[ax] + CW'(1) : cpos[ax] - CW'(1);
    hit      = spos ? (cell_new == G_C) : (cell_new == '1);
    tsum     = {1'b0, ncross[ax]} + {1'b0, cstep[ax]};
    mcnt_next = mcnt + 7'd1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = mem_rdata + darken;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (state == S_MWRITE) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state == S_IDLE) ? read_index : cur_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      darken <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      darken <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
      mcnt    <= '0;
      didx    <= '0;
      for (int i = 0; i < 3; i++) begin
        cpos[i]   <= '0;
        ncross[i] <= '0;
        cstep[i]  <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (action == vrt_pkg::ACT_READ) begin
              state <= S_RDWAIT;
            end else if (out_of_grid) begin
              done         <= 1'b1;
              voxel_value  <= '0;
              marked_count <= '0;
              rejected     <= 1'b1;
            end else begin
              dir_r[0]  <= dir_x;
              dir_r[1]  <= dir_y;
              dir_r[2]  <= dir_z;
              frac_r[0] <= origin_x[7:0];
              frac_r[1] <= origin_y[7:0];
              frac_r[2] <= origin_z[7:0];
              cpos[0]   <= CW'(ip_x);
              cpos[1]   <= CW'(ip_y);
              cpos[2]   <= CW'(ip_z);
              didx      <= '0;
              state     <= S_DIVGO;
            end
          end
        end
        S_RDWAIT: begin
          done         <= 1'b1;
          voxel_value  <= mem_rdata;
          marked_count <= '0;
          rejected     <= 1'b0;
          state        <= S_IDLE;
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (ddone) begin
            if (didx[0]) begin
              ncross[dax] <= dval;
            end else begin
              cstep[dax] <= dval;
            end
            if (didx == 3'd5) begin
              mcnt  <= '0;
              state <= S_MREAD;
            end else begin
              didx  <= didx + 3'd1;
              state <= S_DIVGO;
            end
          end
        end
        S_MREAD: begin
          state <= S_MWRITE;
        end
        S_MWRITE: begin
          mcnt <= mcnt_next;
          if (hit) begin
            cpos[ax]     <= cell_new;
            done         <= 1'b1;
            voxel_value  <= '0;
            marked_count <= mcnt_next;
            rejected     <= 1'b0;
            state        <= S_IDLE;
          end else begin
            cpos[ax]   <= cell_new;
            ncross[ax] <= tsum[vrt_pkg::T_W] ? vrt_pkg::T_NEVER : tsum[vrt_pkg::T_W-1:0];
            state      <= S_MREAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vrt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  vrt_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_reject_no_marks: assert property (@(posedge clk) disable iff (rst)
    done && rejected |-> marked_count == 7'd0 && voxel_value == 8'd0)
    else $error("rejected result carries data");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept && action == vrt_pkg::ACT_READ |=> busy)
    else $error("read item did not hold busy");

  a_walk_write_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_MWRITE |-> cpos[0] >= 0 && cpos[0] < G_C && cpos[1] >= 0 &&
      cpos[1] < G_C && cpos[2] >= 0 && cpos[2] < G_C)
    else $error("voxel write outside grid");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> busy && !done)
    else $error("activity during store clear");

endmodule
`default_nettype wire

### verif/tb_voxel_ray_traversal_accumulate.sv
// testbench for voxel_ray_traversal_accumulate: cast and read items against a
// behavioral DDA walk over a shadow voxel store, with darken amount changes
// depends on vrt_pkg and the block's rtl
`timescale 1ns / 100ps
`default_nettype none

class voxel_scoreboard;
  typedef struct {
    logic [7:0] value;
    logic [6:0] count;
    logic       rej;
  } voxel_result_t;

  localparam int GS = 32;
  logic [7:0]    shadow_store [32768];
  logic [7:0]    darken;
  voxel_result_t pending_q [$];
  int            mismatches;
  int            casts, reads, rejects, results_seen;

  function void clear_all();
    foreach (shadow_store[i]) shadow_store[i] = '0;
    darken = 8'd1;
    pending_q.delete();
  endfunction

  function void mark_voxel(int x, int y, int z, inout logic [6:0] cnt);
    logic [14:0] a;
    a = 15'(x + GS * y + GS * GS * z);
    shadow_store[a] = shadow_store[a] + darken;
    cnt = cnt + 7'd1;
  endfunction

  // note one accepted input beat and queue its expected result
  function void note_item(logic act, logic [12:0] org [3], logic signed [15:0] dir [3],
                          logic [14:0] idx);
    voxel_result_t r;
    int            cpos [3], stp [3], bnd [3];
    logic [31:0]   tnext [3], tstep [3], mag, span, s;
    int            ax;
    r = '{8'd0, 7'd0, 1'b0};
    if (act == vrt_pkg::ACT_READ) begin
      r.value = shadow_store[idx];
      reads++;
      pending_q.push_back(r);
      return;
    end
    for (int i = 0; i < 3; i++) cpos[i] = org[i] >> 8;
    if (cpos[0] >= GS || cpos[1] >= GS || cpos[2] >= GS) begin
      r.rej = 1'b1;
      rejects++;
      pending_q.push_back(r);
      return;
    end
    casts++;
    for (int i = 0; i < 3; i++) begin
      stp[i] = (dir[i] > 0) ? 1 : -1;
      bnd[i] = (dir[i] > 0) ? GS : -1;
      if (dir[i] == 0) begin
        tnext[i] = '1;
        tstep[i] = '1;
      end else begin
        mag = dir[i][15] ? 32'(-32'(dir[i])) : 32'(dir[i]);
        span = (dir[i] > 0) ? 32'(256 - org[i][7:0]) : 32'(org[i][7:0]);
        tstep[i] = (32'd1 << 24) / mag;
        tnext[i] = (span << 16) / mag;
      end
    end
    mark_voxel(cpos[0], cpos[1], cpos[2], r.count);
    forever begin
      if (tnext[0] < tnext[1]) ax = (tnext[0] < tnext[2]) ? 0 : 2;
      else ax = (tnext[1] < tnext[2]) ? 1 : 2;
      cpos[ax] += stp[ax];
      if (cpos[ax] == bnd[ax]) break;
      s = tnext[ax] + tstep[ax];
      tnext[ax] = (s < tnext[ax]) ? 32'hFFFF_FFFF : s;
      if (cpos[ax] < 0 || cpos[ax] >= GS) break;
      mark_voxel(cpos[0], cpos[1], cpos[2], r.count);
    end
    pending_q.push_back(r);
  endfunction

  function void report(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endfunction

  function void check_result(logic [7:0] v, logic [6:0] c, logic rj);
    voxel_result_t e;
    results_seen++;
    if (pending_q.size() == 0) begin
      report("result with nothing outstanding");
      return;
    end
    e = pending_q.pop_front();
    if (v !== e.value) report($sformatf("voxel_value %0d, wanted %0d", v, e.value));
    if (c !== e.count) report($sformatf("marked_count %0d, wanted %0d", c, e.count));
    if (rj !== e.rej) report($sformatf("rejected %0b, wanted %0b", rj, e.rej));
  endfunction
endclass

module tb_voxel_ray_traversal_accumulate;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy, done, rejected, cfg_ready;
  logic        action = 1'b0;
  logic [12:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic [14:0] read_index = '0;
  logic [7:0]  voxel_value, cfg_data = '0;
  logic [6:0]  marked_count;
  logic        cfg_valid = 1'b0;
  int          send_idle_pct;
  longint      cycle_count = 0;
  voxel_scoreboard board;

  localparam longint CYCLE_LIMIT = 4_000_000;

  always #1 clk = ~clk;

  voxel_ray_traversal_accumulate u_top (
    .clk, .rst, .start, .busy, .action, .origin_x, .origin_y, .origin_z,
    .dir_x, .dir_y, .dir_z, .read_index, .done, .voxel_value, .marked_count,
    .rejected, .cfg_valid, .cfg_ready, .cfg_data
  );

  always @(posedge clk) begin
    if (!rst && done) board.check_result(voxel_value, marked_count, rejected);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("voxel_ray_traversal_accumulate regression: fail");
      $finish;
    end
  end

  // one item beat, with random idle cycles ahead of it; start stays up after
  // the accepting edge until the next beat or an idle cycle replaces it
  task automatic send_item(logic act, logic [12:0] ox, logic [12:0] oy, logic [12:0] oz,
                           logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                           logic [14:0] idx);
    logic [12:0]        org [3];
    logic signed [15:0] dir [3];
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    read_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    org = '{ox, oy, oz};
    dir = '{dx, dy, dz};
    board.note_item(act, org, dir, idx);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_darken(logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.darken = val;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h8000;
      4: return 16'($urandom_range(40) - 20);
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  task automatic rand_cast();
    logic [12:0] o [3];
    for (int i = 0; i < 3; i++)
      o[i] = ($urandom_range(19) == 0) ? 13'($urandom) : 13'($urandom_range(8191 >> 1));
    send_item(vrt_pkg::ACT_CAST, o[0], o[1], o[2], rand_dir(), rand_dir(), rand_dir(),
              15'($urandom));
  endtask

  task automatic rand_read();
    send_item(vrt_pkg::ACT_READ, 13'($urandom), 13'($urandom), 13'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom));
  endtask

  initial begin
    board = new();
    board.clear_all();
    send_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: axis walks, ties, zero direction, extremes, reads
    send_item(vrt_pkg::ACT_CAST, 13'h0080, 13'h0080, 13'h0080, 16'h4000, 16'h0, 16'h0, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h1F80, 13'h0080, 13'h0080, 16'h0, 16'h4000, 16'h0, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h1000, 13'h1000, 13'h1000, 16'h0, 16'h0, 16'h0, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h0000, 13'h0000, 13'h0000, 16'h4000, 16'h4000,
              16'h4000, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h1FFF, 13'h1FFF, 13'h1FFF, 16'h8000, 16'h8000,
              16'h8000, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h1FFF, 13'h1FFF, 13'h1FFF, 16'hC000, 16'hC000,
              16'hC000, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h0000, 13'h1F00, 13'h0A55, 16'h0001, 16'hFFFF,
              16'h7FFF, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h1FFF, 13'h0, 13'h0, 16'h4000, 16'h0, 16'h0, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h0, 13'h0, 13'h1FFF, 16'h4000, 16'h0, 16'h0, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h0, 13'h0, 13'h0, 16'h0, 16'h0, 16'h0, '0);
    send_item(vrt_pkg::ACT_CAST, 13'h1F00, 13'h1F00, 13'h1F00, 16'h2AAB, 16'hD555,
              16'h1234, '0);
    send_item(vrt_pkg::ACT_READ, '0, '0, '0, '0, '0, '0, 15'd0);
    send_item(vrt_pkg::ACT_READ, '0, '0, '0, '0, '0, '0, 15'h7FFF);
    send_item(vrt_pkg::ACT_READ, '0, '0, '0, '0, '0, '0, 15'd1057);
    write_darken(8'd255);
    send_item(vrt_pkg::ACT_CAST, 13'h0080, 13'h0080, 13'h0080, 16'h4000, 16'h0, 16'h0, '0);
    send_item(vrt_pkg::ACT_READ, '0, '0, '0, '0, '0, '0, 15'd1057);
    write_darken(8'd0);
    send_item(vrt_pkg::ACT_CAST, 13'h0580, 13'h0200, 13'h0F00, 16'h1000, 16'hF000,
              16'h0800, '0);
    send_item(vrt_pkg::ACT_READ, '0, '0, '0, '0, '0, '0, 15'd1057);

    // random phases, darken changed between them
    for (int ph = 0; ph < 5; ph++) begin
      write_darken(ph == 0 ? 8'd1 : 8'($urandom));
      send_idle_pct = (ph == 1) ? 72 : (ph == 3) ? 17 : 0;
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(99) < 70) rand_cast();
        else rand_read();
        if (n == 50) drain();
      end
    end

    drain();
    $display("covered %0d walks, %0d rejected origins, %0d voxel reads, %0d results",
             board.casts, board.rejects, board.reads, board.results_seen);
    if (board.mismatches == 0 && board.pending_q.size() == 0)
      $display("voxel_ray_traversal_accumulate regression: pass");
    else
      $display("voxel_ray_traversal_accumulate regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
src/vrt_pkg.sv
src/vrt_mem.sv
src/vrt_div.sv
src/voxel_ray_traversal_accumulate.sv
verif/tb_voxel_ray_traversal_accumulate.sv
